// ===== rtl/core/agwc_pkg.sv =====
`timescale 1ns / 1ps

package agwc_pkg;

    localparam int AGWC_STREAMS = 16;

    // item field widths
    localparam int IDX_W     = 4;
    localparam int TIME_W    = 48;
    localparam int ERR_W     = TIME_W + 1;
    localparam int GUARD_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int PROD_W    = GAIN_W + TIME_W;
    localparam int PROD_HI_W = PROD_W - GAIN_FRAC;

    // register port
    localparam int PADDR_W      = 6;
    localparam int PDATA_W      = 64;
    localparam int REG_ADDR_LSB = 3;
    localparam int REG_IDX_W    = PADDR_W - REG_ADDR_LSB;

    localparam logic [REG_IDX_W-1:0] REG_GUARD_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIXED_GUARD  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_GUARD   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GUARD_GAIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_GUARD    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_GUARD    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_INTERVAL = 3'd6;

    localparam logic                RST_GUARD_MODE    = 1'b0;
    localparam logic [GUARD_W-1:0]  RST_FIXED_GUARD   = 32'd200000;
    localparam logic [GUARD_W-1:0]  RST_BASE_GUARD    = 32'd50000;
    localparam logic [GAIN_W-1:0]   RST_GUARD_GAIN    = 16'd2048;
    localparam logic [GUARD_W-1:0]  RST_MIN_GUARD     = 32'd10000;
    localparam logic [GUARD_W-1:0]  RST_MAX_GUARD     = 32'd1000000;
    localparam logic [TIME_W-1:0]   RST_SLOT_INTERVAL = 48'd30000000000;

    typedef struct packed {
        logic               guard_mode;
        logic [GUARD_W-1:0] fixed_guard_ns;
        logic [GUARD_W-1:0] base_guard_ns;
        logic [GAIN_W-1:0]  guard_gain;
        logic [GUARD_W-1:0] min_guard_ns;
        logic [GUARD_W-1:0] max_guard_ns;
        logic [TIME_W-1:0]  slot_interval_ns;
    } t_cfg;

    // tracker stage to guard stage
    typedef struct packed {
        logic                    bad;
        logic                    first;
        logic signed [ERR_W-1:0] err;
        logic [TIME_W-1:0]       abs_err;
        logic [PROD_HI_W-1:0]    prod_hi;
    } t_s2;

endpackage

// ===== rtl/core/agwc_ifs.sv =====
`timescale 1ns / 1ps

interface agwc_in_if;
    import agwc_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  stream_index;
    logic [TIME_W-1:0] arrival_time_ns;

    modport source(output valid, output stream_index, output arrival_time_ns, input ready);
    modport sink(input valid, input stream_index, input arrival_time_ns, output ready);
endinterface

interface agwc_out_if;
    import agwc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    in_window;
    logic signed [ERR_W-1:0] arrival_error_ns;
    logic [GUARD_W-1:0]      guard_used_ns;

    modport source(output valid, output in_window, output arrival_error_ns,
                   output guard_used_ns, input ready);
    modport sink(input valid, input in_window, input arrival_error_ns,
                 input guard_used_ns, output ready);
endinterface

// ===== rtl/core/agwc_ram.sv =====
`timescale 1ns / 1ps

module agwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/agwc_cfg.sv =====
`timescale 1ns / 1ps

module agwc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [agwc_pkg::PADDR_W-1:0]  paddr,
    input  logic [agwc_pkg::PDATA_W-1:0]  pwdata,
    output logic [agwc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output agwc_pkg::t_cfg                o_cfg
);
    import agwc_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:REG_ADDR_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.guard_mode       <= RST_GUARD_MODE;
            r_cfg.fixed_guard_ns   <= RST_FIXED_GUARD;
            r_cfg.base_guard_ns    <= RST_BASE_GUARD;
            r_cfg.guard_gain       <= RST_GUARD_GAIN;
            r_cfg.min_guard_ns     <= RST_MIN_GUARD;
            r_cfg.max_guard_ns     <= RST_MAX_GUARD;
            r_cfg.slot_interval_ns <= RST_SLOT_INTERVAL;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GUARD_MODE:    r_cfg.guard_mode       <= pwdata[0];
                REG_FIXED_GUARD:   r_cfg.fixed_guard_ns   <= pwdata[GUARD_W-1:0];
                REG_BASE_GUARD:    r_cfg.base_guard_ns    <= pwdata[GUARD_W-1:0];
                REG_GUARD_GAIN:    r_cfg.guard_gain       <= pwdata[GAIN_W-1:0];
                REG_MIN_GUARD:     r_cfg.min_guard_ns     <= pwdata[GUARD_W-1:0];
                REG_MAX_GUARD:     r_cfg.max_guard_ns     <= pwdata[GUARD_W-1:0];
                REG_SLOT_INTERVAL: r_cfg.slot_interval_ns <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GUARD_MODE:    prdata = PDATA_W'(r_cfg.guard_mode);
            REG_FIXED_GUARD:   prdata = PDATA_W'(r_cfg.fixed_guard_ns);
            REG_BASE_GUARD:    prdata = PDATA_W'(r_cfg.base_guard_ns);
            REG_GUARD_GAIN:    prdata = PDATA_W'(r_cfg.guard_gain);
            REG_MIN_GUARD:     prdata = PDATA_W'(r_cfg.min_guard_ns);
            REG_MAX_GUARD:     prdata = PDATA_W'(r_cfg.max_guard_ns);
            REG_SLOT_INTERVAL: prdata = PDATA_W'(r_cfg.slot_interval_ns);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// ===== rtl/core/agwc_track.sv =====
`timescale 1ns / 1ps

module agwc_track #(
    parameter int STREAMS = agwc_pkg::AGWC_STREAMS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    agwc_in_if.sink        i_item,
    input  agwc_pkg::t_cfg i_cfg,
    input  logic           i_next_ready,
    output logic           o_valid,
    output agwc_pkg::t_s2  o_s2
);
    import agwc_pkg::*;

    localparam int AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int SW = 2 * TIME_W;

    logic               r_v1;
    logic [AW-1:0]      r_addr;
    logic [TIME_W-1:0]  r_arr;
    logic               r_bad;
    logic               r_hit;
    logic [STREAMS-1:0] r_vbits;
    logic               r_fwd;
    logic [TIME_W-1:0]  r_fwd_exp;
    logic [TIME_W-1:0]  r_fwd_abs;

    logic               en_1;
    logic               accept;
    logic               wr;
    logic [AW-1:0]      a_in;
    logic               bad_in;
    logic               vb_sel;
    logic               hit_in;
    logic [SW-1:0]      ram_rdata;
    logic [TIME_W-1:0]  exp_cur;
    logic [TIME_W-1:0]  abs_last;
    logic [TIME_W:0]    diff;
    logic [TIME_W:0]    neg_diff;
    logic [TIME_W-1:0]  abs_err;
    logic [TIME_W:0]    adv_sum;
    logic [TIME_W-1:0]  n_exp;
    logic [TIME_W-1:0]  n_abs;
    logic [PROD_W-1:0]  prod;

    assign en_1        = !r_v1 || i_next_ready;
    assign i_item.ready = en_1;
    assign accept      = i_item.valid && en_1;
    // the stage writes its state back as it hands the item on
    assign wr          = r_v1 && i_next_ready && !r_bad;

    assign a_in   = AW'(i_item.stream_index);
    assign bad_in = 32'(i_item.stream_index) >= 32'(STREAMS);
    assign vb_sel = bad_in ? 1'b0 : r_vbits[a_in];
    assign hit_in = !bad_in && (vb_sel || (wr && (r_addr == a_in)));

    agwc_ram #(
        .WIDTH(SW),
        .DEPTH(STREAMS)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr(r_addr),
        .i_wdata({n_exp, n_abs}),
        .i_re   (accept && !bad_in),
        .i_raddr(a_in),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_vbits <= '0;
            r_fwd   <= 1'b0;
        end else begin
            if (en_1) begin
                r_v1 <= i_item.valid;
            end
            if (wr) begin
                r_vbits[r_addr] <= 1'b1;
            end
            if (accept) begin
                // same stream back to back: ram read misses the write
                r_fwd <= wr && !bad_in && (r_addr == a_in);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr    <= a_in;
            r_arr     <= i_item.arrival_time_ns;
            r_bad     <= bad_in;
            r_hit     <= hit_in;
            r_fwd_exp <= n_exp;
            r_fwd_abs <= n_abs;
        end
    end

    assign exp_cur  = r_fwd ? r_fwd_exp : ram_rdata[SW-1:TIME_W];
    assign abs_last = r_fwd ? r_fwd_abs : ram_rdata[TIME_W-1:0];

    assign diff     = {1'b0, r_arr} - {1'b0, exp_cur};
    assign neg_diff = -diff;
    assign abs_err  = diff[TIME_W] ? neg_diff[TIME_W-1:0] : diff[TIME_W-1:0];

    // next expected time, saturating
    assign adv_sum = {1'b0, (r_hit ? exp_cur : r_arr)} + {1'b0, i_cfg.slot_interval_ns};
    assign n_exp   = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];
    assign n_abs   = r_hit ? abs_err : '0;

    assign prod = PROD_W'(i_cfg.guard_gain) * PROD_W'(abs_last);

    assign o_valid         = r_v1;
    assign o_s2.bad        = r_bad;
    assign o_s2.first      = !r_hit;
    assign o_s2.err        = diff;
    assign o_s2.abs_err    = abs_err;
    assign o_s2.prod_hi    = prod[PROD_W-1:GAIN_FRAC];

    a_hit_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !r_bad && r_hit |-> r_vbits[r_addr])
        else $error("tracked stream has no valid bit");

    a_first_not_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !r_bad && !r_hit |-> n_exp >= r_arr)
        else $error("expected time armed before arrival");

    a_fwd_same_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_fwd |-> !r_bad && r_hit && r_vbits[r_addr])
        else $error("bypass taken without a matching write");
endmodule

// ===== rtl/core/agwc_guard.sv =====
`timescale 1ns / 1ps

module agwc_guard (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  agwc_pkg::t_s2  i_s2,
    input  agwc_pkg::t_cfg i_cfg,
    output logic           o_ready,
    agwc_out_if.source     o_result
);
    import agwc_pkg::*;

    localparam int SUM_W = PROD_HI_W + 1;

    logic                    r_v2;
    t_s2                     r_s2;
    logic                    r_vo;
    logic                    r_in_window;
    logic signed [ERR_W-1:0] r_err;
    logic [GUARD_W-1:0]      r_guard;

    logic                    en_o;
    logic                    en_2;
    logic [SUM_W-1:0]        gsum;
    logic [SUM_W-1:0]        g_lo;
    logic [SUM_W-1:0]        g_hi;
    logic [GUARD_W-1:0]      prop_guard;
    logic [GUARD_W-1:0]      active_guard;
    logic [ERR_W-1:0]        neg_err;
    logic                    n_in_window;
    logic signed [ERR_W-1:0] n_err;
    logic [GUARD_W-1:0]      n_guard;

    assign en_o    = !r_vo || o_result.ready;
    assign en_2    = !r_v2 || en_o;
    assign o_ready = en_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_2) begin
                r_v2 <= i_valid;
            end
            if (en_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_2) begin
            r_s2 <= i_s2;
        end
        if (en_o) begin
            r_in_window <= n_in_window;
            r_err       <= n_err;
            r_guard     <= n_guard;
        end
    end

    // base + gain * last error, min clamp then max clamp
    assign gsum       = SUM_W'(r_s2.prod_hi) + SUM_W'(i_cfg.base_guard_ns);
    assign g_lo       = (gsum < SUM_W'(i_cfg.min_guard_ns)) ? SUM_W'(i_cfg.min_guard_ns) : gsum;
    assign g_hi       = (g_lo > SUM_W'(i_cfg.max_guard_ns)) ? SUM_W'(i_cfg.max_guard_ns) : g_lo;
    assign prop_guard = g_hi[GUARD_W-1:0];

    assign active_guard = i_cfg.guard_mode ? prop_guard : i_cfg.fixed_guard_ns;
    assign neg_err      = -r_s2.err;

    always_comb begin
        if (r_s2.bad) begin
            n_in_window = 1'b0;
            n_err       = '0;
            n_guard     = '0;
        end else if (r_s2.first) begin
            n_in_window = 1'b1;
            n_err       = '0;
            n_guard     = i_cfg.guard_mode ? i_cfg.base_guard_ns : i_cfg.fixed_guard_ns;
        end else begin
            n_in_window = r_s2.abs_err <= TIME_W'(active_guard);
            n_err       = r_s2.err;
            n_guard     = active_guard;
        end
    end

    assign o_result.valid            = r_vo;
    assign o_result.in_window        = r_in_window;
    assign o_result.arrival_error_ns = r_err;
    assign o_result.guard_used_ns    = r_guard;

    a_abs_matches_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_s2.bad && !r_s2.first |->
            r_s2.abs_err == (r_s2.err[ERR_W-1] ? neg_err[TIME_W-1:0] : r_s2.err[TIME_W-1:0]))
        else $error("magnitude and signed error disagree");

    a_prop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_s2.bad && !r_s2.first && i_cfg.guard_mode
            && (i_cfg.min_guard_ns <= i_cfg.max_guard_ns) |->
            (prop_guard >= i_cfg.min_guard_ns) && (prop_guard <= i_cfg.max_guard_ns))
        else $error("proportional guard outside clamp range");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !o_result.ready |=>
            r_vo && $stable(r_in_window) && $stable(r_err) && $stable(r_guard))
        else $error("result changed while stalled");
endmodule

// ===== rtl/core/adaptive_guard_window_checker.sv =====
`timescale 1ns / 1ps
// port        dir  kind          carries
// i_item      in   valid/ready   stream_index, arrival_time_ns
// o_result    out  valid/ready   in_window, arrival_error_ns, guard_used_ns
// psel..      in   apb           register writes/reads, 8-byte stride
//
// one item per cycle sustained while o_result.ready holds; each stage below ends in a register
// stages: state ram read, error/next-time/gain multiply, clamp/compare into output reg
// per-stream state in a one-write one-read ram with a bypass for back-to-back hits
// i_rst_n synchronous; stream valid bits all clear together on reset, no clearing pass
// a stall on o_result fills the pipeline before i_item.ready drops

module adaptive_guard_window_checker #(
    parameter int STREAMS = agwc_pkg::AGWC_STREAMS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    agwc_in_if.sink                       i_item,
    agwc_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [agwc_pkg::PADDR_W-1:0]  paddr,
    input  logic [agwc_pkg::PDATA_W-1:0]  pwdata,
    output logic [agwc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import agwc_pkg::*;

    t_cfg cfg;
    t_s2  s2;
    logic s1_valid;
    logic s2_ready;

    agwc_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    agwc_track #(
        .STREAMS(STREAMS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .i_next_ready(s2_ready),
        .o_valid     (s1_valid),
        .o_s2        (s2)
    );

    agwc_guard u_guard (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s2    (s2),
        .i_cfg   (cfg),
        .o_ready (s2_ready),
        .o_result(o_result)
    );
endmodule
